// File: rtl/core/crfp_pkg.sv
// shared types and constants of the csv record and field parser
`default_nettype none

package crfp_pkg;

   // largest field index the counter reaches before it saturates
   localparam int MAX_FIELD_INDEX = 255;
   localparam int FIELD_CNT_W     = $clog2(MAX_FIELD_INDEX + 1);

   // payload widths
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 8;

   // bytes with a special meaning
   localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
   localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

   // result kinds
   typedef enum logic [1:0] {
      KIND_BYTE        = 2'd0,
      KIND_FIELD_END   = 2'd1,
      KIND_RECORD_END  = 2'd2,
      KIND_RECORD_ONLY = 2'd3
   } kind_type;

endpackage : crfp_pkg

`default_nettype wire

// File: rtl/core/crfp_req_if.sv
// input channel of the csv parser: one file byte or an end-of-file mark
`default_nettype none

interface crfp_req_if;
   import crfp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              flush;

   modport source (output valid, output in_byte, output flush, input ready);
   modport sink   (input valid, input in_byte, input flush, output ready);
endinterface : crfp_req_if

`default_nettype wire

// File: rtl/core/crfp_rsp_if.sv
// result channel of the csv parser: field bytes and field or record marks
`default_nettype none

interface crfp_rsp_if;
   import crfp_pkg::*;

   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [BYTE_W-1:0]  out_byte;
   logic [INDEX_W-1:0] field_index;

   modport source (output valid, output kind, output out_byte, output field_index,
                   input ready);
   modport sink   (input valid, input kind, input out_byte, input field_index,
                   output ready);
endinterface : crfp_rsp_if

`default_nettype wire

// File: rtl/core/csv_record_field_parser.sv
// csv record and field parser: one byte in per cycle while rsp takes each result, at most one result out
// result: registered, shows on rsp in the cycle after its byte is accepted
// throughput: one item per cycle while rsp takes each result; the parse state update is a single
// combinational step, and the result register frees itself when rsp takes it
// reset: synchronous, clears the parse state and empties the result register
`default_nettype none

module csv_record_field_parser (
   input  wire logic   clock,
   input  wire logic   reset,
   crfp_req_if.sink    req_chan,
   crfp_rsp_if.source  rsp_chan
);
   import crfp_pkg::*;

   typedef enum logic [1:0] {
      MODE_START  = 2'd0,
      MODE_PLAIN  = 2'd1,
      MODE_QUOTED = 2'd2,
      MODE_QSEEN  = 2'd3
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic                   parity_ff, parity_in;
   logic                   has_bytes_ff, has_bytes_in;
   logic [FIELD_CNT_W-1:0] cnt_ff, cnt_in;

   logic                   rsp_valid_ff;
   kind_type               kind_ff, kind_in;
   logic [BYTE_W-1:0]      byte_ff, byte_in;
   logic [INDEX_W-1:0]     index_ff, index_in;
   logic                   emit_in;

   logic                   accept;
   logic [BYTE_W-1:0]      b;
   logic                   par_next;
   logic [31:0]            cnt_ext;
   logic [INDEX_W-1:0]     cur_index;
   logic [FIELD_CNT_W-1:0] cnt_step;

   // the result register frees whenever its item is taken
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.in_byte;
   assign par_next       = parity_ff ^ (b == CH_QUOTE);

   // field index as shown on the result, saturating at 255
   assign cnt_ext   = 32'(cnt_ff);
   assign cur_index = (cnt_ext > 32'd255) ? 8'hFF : cnt_ext[INDEX_W-1:0];
   assign cnt_step  = (cnt_ext < 32'(MAX_FIELD_INDEX)) ? cnt_ff + FIELD_CNT_W'(1) : cnt_ff;

   // per-byte parse step
   always_comb begin
      mode_in      = mode_ff;
      parity_in    = parity_ff;
      has_bytes_in = has_bytes_ff;
      cnt_in       = cnt_ff;
      emit_in      = 1'b0;
      kind_in      = KIND_BYTE;
      byte_in      = '0;
      index_in     = cur_index;

      if (req_chan.flush || (!par_next && b == CH_LF)) begin
         // record end: close an open field or mark a record with kept bytes
         if (mode_ff != MODE_START) begin
            emit_in = 1'b1;
            kind_in = KIND_RECORD_END;
         end else if (has_bytes_ff) begin
            emit_in = 1'b1;
            kind_in = KIND_RECORD_ONLY;
         end
         mode_in      = MODE_START;
         parity_in    = 1'b0;
         has_bytes_in = 1'b0;
         cnt_in       = '0;
      end else if (!par_next && b == CH_CR) begin
         // dropped carriage return, nothing changes
      end else begin
         parity_in    = par_next;
         has_bytes_in = 1'b1;
         unique case (mode_ff)
            MODE_START: begin
               if (b == CH_QUOTE) begin
                  mode_in = MODE_QUOTED;
               end else if (b == CH_COMMA) begin
                  emit_in = 1'b1;
                  kind_in = KIND_FIELD_END;
                  cnt_in  = cnt_step;
               end else begin
                  mode_in = MODE_PLAIN;
                  emit_in = 1'b1;
                  byte_in = b;
               end
            end
            MODE_PLAIN: begin
               emit_in = 1'b1;
               if (b == CH_COMMA) begin
                  kind_in = KIND_FIELD_END;
                  cnt_in  = cnt_step;
                  mode_in = MODE_START;
               end else begin
                  byte_in = b;
               end
            end
            MODE_QUOTED: begin
               if (b == CH_QUOTE) begin
                  mode_in = MODE_QSEEN;
               end else begin
                  emit_in = 1'b1;
                  byte_in = b;
               end
            end
            MODE_QSEEN: begin
               emit_in = 1'b1;
               if (b == CH_QUOTE) begin
                  // doubled quote gives one quote
                  mode_in = MODE_QUOTED;
                  byte_in = b;
               end else begin
                  // byte after the closing quote is the separator
                  kind_in = KIND_FIELD_END;
                  cnt_in  = cnt_step;
                  mode_in = MODE_START;
               end
            end
            default: begin
               mode_in = MODE_START;
            end
         endcase
      end
   end

   // parse state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_START;
         parity_ff    <= 1'b0;
         has_bytes_ff <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff      <= mode_in;
            parity_ff    <= parity_in;
            has_bytes_ff <= has_bytes_in;
            cnt_ff       <= cnt_in;
            rsp_valid_ff <= emit_in;
            kind_ff      <= kind_in;
            byte_ff      <= byte_in;
            index_ff     <= index_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.kind        = kind_ff;
   assign rsp_chan.out_byte    = byte_ff;
   assign rsp_chan.field_index = index_ff;

endmodule : csv_record_field_parser

`default_nettype wire
